[hdl/bdtd_pkg.sv]
// Shared types and constants for the bus data type decoder.
// No dependencies.
`default_nettype none

package bdtd_pkg;

    localparam int OP_W     = 4;
    localparam int RAW_W    = 32;
    localparam int FACTOR_W = 16;
    localparam int VALUE_W  = 49;
    localparam int CODE_W   = 3;
    localparam int NUM_W    = RAW_W + 1;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_UCH = 4'd0;
    localparam op_t OP_SCH = 4'd1;
    localparam op_t OP_UIN = 4'd2;
    localparam op_t OP_SIN = 4'd3;
    localparam op_t OP_ULG = 4'd4;
    localparam op_t OP_SLG = 4'd5;
    localparam op_t OP_FLT = 4'd6;
    localparam op_t OP_BCD = 4'd7;
    localparam op_t OP_D1B = 4'd8;
    localparam op_t OP_D1C = 4'd9;
    localparam op_t OP_D2B = 4'd10;
    localparam op_t OP_D2C = 4'd11;

    typedef logic [CODE_W-1:0] scale_code_t;

    localparam scale_code_t SCALE_ONE      = 3'd0;
    localparam scale_code_t SCALE_HALF     = 3'd1;
    localparam scale_code_t SCALE_SIXTEEN  = 3'd2;
    localparam scale_code_t SCALE_256      = 3'd3;
    localparam scale_code_t SCALE_THOUSAND = 3'd4;

    localparam logic [7:0] D1C_MAX      = 8'hC8;
    localparam logic [7:0] INVALID_BYTE = 8'hFF;
    localparam logic [3:0] BCD_MAX      = 4'h9;

    typedef struct packed {
        logic [VALUE_W-1:0] scaled_value;
        scale_code_t        scale_code;
        logic               invalid;
    } result_t;

endpackage

`default_nettype wire

[hdl/bdtd_decode.sv]
// Decodes one raw field to a numerator and scale code, then applies the factor.
// Depends on bdtd_pkg.
`default_nettype none

module bdtd_decode
    import bdtd_pkg::*;
(
    input  wire op_t                 op,
    input  wire logic [RAW_W-1:0]    raw_value,
    input  wire logic [FACTOR_W-1:0] scale_factor,
    output result_t                  result
);

    logic signed [NUM_W-1:0]      num;
    logic signed [FACTOR_W:0]     factor_s;
    logic signed [NUM_W+FACTOR_W:0] product;
    scale_code_t                  code;
    logic                         fixed255;
    logic                         bad_op;
    logic [3:0]                   bcd_hi;
    logic [3:0]                   bcd_lo;
    logic [7:0]                   bcd_sum;

    assign bcd_hi  = raw_value[7:4];
    assign bcd_lo  = raw_value[3:0];
    assign bcd_sum = {1'b0, bcd_hi, 3'b000} + {3'b000, bcd_hi, 1'b0} + {4'h0, bcd_lo};

    always_comb begin
        num      = '0;
        code     = SCALE_ONE;
        fixed255 = 1'b0;
        bad_op   = 1'b0;
        case (op)
            OP_UCH: num = {{(NUM_W-8){1'b0}}, raw_value[7:0]};
            OP_SCH, OP_D1B: num = {{(NUM_W-8){raw_value[7]}}, raw_value[7:0]};
            OP_UIN: num = {{(NUM_W-16){1'b0}}, raw_value[15:0]};
            OP_SIN: num = {{(NUM_W-16){raw_value[15]}}, raw_value[15:0]};
            OP_ULG: num = {1'b0, raw_value};
            OP_SLG: num = {raw_value[RAW_W-1], raw_value};
            OP_FLT: begin
                num  = {{(NUM_W-16){raw_value[15]}}, raw_value[15:0]};
                code = SCALE_THOUSAND;
            end
            OP_BCD: begin
                if (bcd_hi > BCD_MAX || bcd_lo > BCD_MAX) begin
                    fixed255 = 1'b1;
                end else begin
                    num = {{(NUM_W-8){1'b0}}, bcd_sum};
                end
            end
            OP_D1C: begin
                if (raw_value[7:0] > D1C_MAX) begin
                    fixed255 = 1'b1;
                end else begin
                    num  = {{(NUM_W-8){1'b0}}, raw_value[7:0]};
                    code = SCALE_HALF;
                end
            end
            OP_D2B: begin
                num  = {{(NUM_W-16){raw_value[15]}}, raw_value[15:0]};
                code = SCALE_256;
            end
            OP_D2C: begin
                num  = {{(NUM_W-16){raw_value[15]}}, raw_value[15:0]};
                code = SCALE_SIXTEEN;
            end
            default: bad_op = 1'b1;
        endcase
    end

    assign factor_s = {1'b0, scale_factor};
    assign product  = num * factor_s;

    always_comb begin
        if (fixed255) begin
            result.scaled_value = {{(VALUE_W-8){1'b0}}, INVALID_BYTE};
            result.scale_code   = SCALE_ONE;
            result.invalid      = 1'b1;
        end else if (bad_op) begin
            result.scaled_value = '0;
            result.scale_code   = SCALE_ONE;
            result.invalid      = 1'b1;
        end else begin
            result.scaled_value = product[VALUE_W-1:0];
            result.scale_code   = code;
            result.invalid      = 1'b0;
        end
    end

endmodule

`default_nettype wire

[hdl/bus_data_type_decoder.sv]
// Top level of the bus data type decoder: input register, decode, result register.
// Depends on bdtd_pkg and bdtd_decode.
`default_nettype none

// Takes one item per cycle while the result side is ready and returns one result
// per item via the input register, then the result register. The input register
// feeds the type decode and a single 33x17 signed multiply, which land in the
// result register; a new item is taken whenever the input register is empty or
// moves on in the same cycle. The scale factor resets to 1; the user must write it
// through the cfg channel only while no items are in flight (not enforced here).

module bus_data_type_decoder
    import bdtd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] raw_value
    input  wire logic [3:0]  s_tuser,   // [3:0] op

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [48:0] scaled_value, [55:49] zero
    output logic [3:0]       m_tuser,   // [2:0] scale_code, [3] invalid

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // scale_factor
);

    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [RAW_W-1:0]    in_raw_reg;
    logic                out_valid_reg;
    result_t             out_result_reg;
    logic [FACTOR_W-1:0] factor_reg;
    result_t             decoded;
    logic                out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= {{(FACTOR_W-1){1'b0}}, 1'b1};
        end else if (cfg_valid) begin
            factor_reg <= cfg_data;
        end
    end

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg  <= s_tuser;
            in_raw_reg <= s_tdata;
        end
    end

    bdtd_decode u_decode (
        .op           (in_op_reg),
        .raw_value    (in_raw_reg),
        .scale_factor (factor_reg),
        .result       (decoded)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(56-VALUE_W){1'b0}}, out_result_reg.scaled_value};
    assign m_tuser  = {out_result_reg.invalid, out_result_reg.scale_code};

endmodule

`default_nettype wire
